>>> rtl/bth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_pkg: shared definitions for the block table heap allocator
// Holds entry flag positions, item and status codes, register indexes and
// the control group that the core broadcasts to the cell row.
// ----------------------------------------------------------------------------
package bth_pkg;

  // Field widths of the channels and the table size register.
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned TBL_CFG_W = 11;

  // Entry flag bit positions.
  localparam int unsigned ENT_TAKEN = 0;
  localparam int unsigned ENT_FIRST = 1;
  localparam int unsigned ENT_NEXT  = 2;
  localparam int unsigned ENT_W     = 3;

  // Item kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BLOCKS = 1'b1;

  // Control group driven from the core to every cell.
  typedef struct packed {
    logic is_free;
    logic mark;
  } ctrl_t;

endpackage

>>> rtl/bth_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_req_if: request channel
// Carries allocate and free items with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface bth_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [bth_pkg::ADDR_W-1:0] request_bytes;
  logic [bth_pkg::ADDR_W-1:0] free_address;

  modport source (output valid, kind, request_bytes, free_address, input ready);
  modport sink   (input valid, kind, request_bytes, free_address, output ready);
endinterface

>>> rtl/bth_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_rsp_if: result channel
// Carries one status and address per item with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface bth_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [bth_pkg::ADDR_W-1:0] address;

  modport source (output valid, status, address, input ready);
  modport sink   (input valid, status, address, output ready);
endinterface

>>> rtl/bth_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_cfg_if: configuration write channel
// Carries a register index and write data with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface bth_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bth_pkg::CFG_IDX_W-1:0] index;
  logic [bth_pkg::ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/block_table_heap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_table_heap_allocator_core: first-fit block table heap allocator
// Keeps one flag entry per heap block in a row of cells and serves
// allocate and free items with a wave that runs along the row.
// ----------------------------------------------------------------------------
// Usage:
//   req carries allocate (kind 0, request_bytes) and free (kind 1,
//   free_address) items. rsp returns one status and address per item.
//   cfg writes heap_base (index 0) and table_blocks (index 1); it is always
//   ready and must only be used while no item is in flight.
// Sequencing:
//   The request transfer starts a wave that moves one table entry per cycle
//   through the whole row of cells; the result is registered once the wave
//   has reached the tail. One item is in work at a time, so a new item is
//   taken only after the last one has run its wave. The block takes the next
//   item while a finished result still waits in the output register.
// Reset:
//   rst clears every table entry to free at once, sets heap_base to 0 and
//   table_blocks to 1024. There is no clearing pass.
// Stalls:
//   When rsp is stalled the result is held; a following item runs its wave
//   and then waits until the held result has been transferred.
// ----------------------------------------------------------------------------
module block_table_heap_allocator_core #(
  parameter int unsigned BLOCK_BYTES = 4096,
  parameter int unsigned MAX_BLOCKS  = 1024
) (
  input logic     clk,
  input logic     rst,
  bth_req_if.sink req,
  bth_rsp_if.source rsp,
  bth_cfg_if.sink cfg
);

  localparam int unsigned SH   = $clog2(BLOCK_BYTES);
  localparam int unsigned IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam logic [IDXW-1:0] LAST_STEP = IDXW'(MAX_BLOCKS - 1);
  localparam logic [bth_pkg::ADDR_W-1:0] OFFS_MASK = bth_pkg::ADDR_W'(BLOCK_BYTES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic [IDXW-1:0] step;

  // Configuration registers.
  logic [bth_pkg::ADDR_W-1:0]   heap_base;
  logic [bth_pkg::TBL_CFG_W-1:0] table_blocks;

  // Item registers.
  logic            kind_q;
  logic            bad_q;
  logic [CNTW-1:0] need_q;
  logic            free_ok_q;
  logic [IDXW-1:0] free_idx_q;

  // Output register.
  logic                       rsp_valid;
  logic                       rsp_status;
  logic [bth_pkg::ADDR_W-1:0] rsp_address;

  logic [CNTW-1:0]            n_used;
  logic [32:0]                need_w;
  logic [bth_pkg::ADDR_W-1:0] diff_w;
  logic [bth_pkg::ADDR_W-1:0] fidx_w;
  logic                       in_xfer;
  logic                       can_finish;
  logic                       alloc_ok;
  bth_pkg::ctrl_t             ctrl;

  // Wave signals between cells.
  logic            w_valid [0:MAX_BLOCKS];
  logic [CNTW-1:0] w_run   [0:MAX_BLOCKS];
  logic [IDXW-1:0] w_start [0:MAX_BLOCKS];
  logic            w_found [0:MAX_BLOCKS];
  logic            w_clr   [0:MAX_BLOCKS];

  logic [CNTW-1:0] mark_end;

  // Entries in use, limited to the built depth.
  assign n_used = (32'(table_blocks) > MAX_BLOCKS) ? CNTW'(MAX_BLOCKS)
                                                   : CNTW'(table_blocks);

  // Request decode: block count rounded up and free block index.
  assign need_w = 33'(req.request_bytes >> SH) + 33'(|(req.request_bytes & OFFS_MASK));
  assign diff_w = req.free_address - heap_base;
  assign fidx_w = diff_w >> SH;

  assign in_xfer    = req.valid && req.ready;
  assign req.ready  = state == ST_IDLE;
  assign cfg.ready  = 1'b1;
  assign can_finish = !rsp_valid || rsp.ready;

  assign alloc_ok = !bad_q && w_found[MAX_BLOCKS];
  assign mark_end = CNTW'(w_start[MAX_BLOCKS]) + need_q;

  always_comb begin
    ctrl.is_free = kind_q == bth_pkg::KIND_FREE;
    ctrl.mark    = state == ST_DONE && can_finish && kind_q == bth_pkg::KIND_ALLOC && alloc_ok;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base    <= '0;
      table_blocks <= bth_pkg::TBL_CFG_W'(1024);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        bth_pkg::CFG_HEAP_BASE:    heap_base    <= cfg.data;
        bth_pkg::CFG_TABLE_BLOCKS: table_blocks <= cfg.data[bth_pkg::TBL_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_q     <= req.kind;
      bad_q      <= (need_w == '0) || (need_w > 33'(n_used));
      need_q     <= CNTW'(need_w);
      free_ok_q  <= fidx_w < 32'(n_used);
      free_idx_q <= IDXW'(fidx_w);
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_SCAN;
      ST_SCAN: if (step == LAST_STEP) state_next = ST_DONE;
      ST_DONE: if (can_finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN && step != LAST_STEP) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && can_finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && can_finish) begin
      if (kind_q == bth_pkg::KIND_FREE || alloc_ok) begin
        rsp_status <= bth_pkg::STATUS_OK;
      end else begin
        rsp_status <= bth_pkg::STATUS_FAIL;
      end
      if (kind_q == bth_pkg::KIND_ALLOC && alloc_ok) begin
        rsp_address <= heap_base + (bth_pkg::ADDR_W'(w_start[MAX_BLOCKS]) << SH);
      end else begin
        rsp_address <= '0;
      end
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.status  = rsp_status;
  assign rsp.address = rsp_address;

  // Wave injection at the head of the row.
  assign w_valid[0] = state == ST_SCAN && step == '0;
  assign w_run[0]   = '0;
  assign w_start[0] = '0;
  assign w_found[0] = 1'b0;
  assign w_clr[0]   = 1'b0;

  // Row of table cells.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    bth_cell #(
      .IDX (i),
      .IDXW(IDXW),
      .CNTW(CNTW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .n_used    (n_used),
      .need      (need_q),
      .free_ok   (free_ok_q),
      .free_idx  (free_idx_q),
      .mark_start(w_start[MAX_BLOCKS]),
      .mark_end  (mark_end),
      .in_valid  (w_valid[i]),
      .in_run    (w_run[i]),
      .in_start  (w_start[i]),
      .in_found  (w_found[i]),
      .in_clr    (w_clr[i]),
      .out_valid (w_valid[i+1]),
      .out_run   (w_run[i+1]),
      .out_start (w_start[i+1]),
      .out_found (w_found[i+1]),
      .out_clr   (w_clr[i+1])
    );
  end

  // The wave reaches the tail of the row right as the sequencer finishes.
  a_wave_tail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && step == LAST_STEP) |=> w_valid[MAX_BLOCKS])
    else $error("scan wave did not reach the tail in time");

  // A failed allocate never reports an address.
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == bth_pkg::STATUS_FAIL) |-> rsp_address == '0)
    else $error("failed allocate carries an address");

  // Marking only happens for an allocate that fits.
  a_mark_alloc: assert property (@(posedge clk) disable iff (rst)
    ctrl.mark |-> (kind_q == bth_pkg::KIND_ALLOC && !bad_q && mark_end <= n_used))
    else $error("run marked for a free or an oversized request");

  // The step counter rests at zero outside the scan.
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCAN |-> step == '0)
    else $error("step counter running outside the scan");

endmodule

>>> rtl/bth_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_cell: one block table entry
// Holds the entry flags, advances the scan or free wave by one position per
// cycle and takes part in the marking of an allocated run.
// ----------------------------------------------------------------------------
module bth_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned IDXW = 10,
  parameter int unsigned CNTW = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  bth_pkg::ctrl_t  ctrl,
  input  logic [CNTW-1:0] n_used,
  input  logic [CNTW-1:0] need,
  input  logic            free_ok,
  input  logic [IDXW-1:0] free_idx,
  input  logic [IDXW-1:0] mark_start,
  input  logic [CNTW-1:0] mark_end,
  input  logic            in_valid,
  input  logic [CNTW-1:0] in_run,
  input  logic [IDXW-1:0] in_start,
  input  logic            in_found,
  input  logic            in_clr,
  output logic            out_valid,
  output logic [CNTW-1:0] out_run,
  output logic [IDXW-1:0] out_start,
  output logic            out_found,
  output logic            out_clr
);

  localparam logic [CNTW-1:0] MY_CNT  = CNTW'(IDX);
  localparam logic [CNTW-1:0] MY_NEXT = CNTW'(IDX + 1);
  localparam logic [IDXW-1:0] MY_IDX  = IDXW'(IDX);

  logic [bth_pkg::ENT_W-1:0] entry;
  logic [bth_pkg::ENT_W-1:0] entry_next;
  logic                      in_use;
  logic                      clear_here;
  logic [CNTW-1:0]           run_next;
  logic [IDXW-1:0]           start_next;
  logic                      found_next;

  assign in_use     = MY_CNT < n_used;
  assign clear_here = in_valid && ctrl.is_free && in_use &&
                      (in_clr || (free_ok && free_idx == MY_IDX));

  // Scan step: extend or restart the current free run.
  always_comb begin
    run_next   = in_run;
    start_next = in_start;
    found_next = in_found;
    if (in_use && !in_found) begin
      if (entry[bth_pkg::ENT_TAKEN]) begin
        run_next = '0;
      end else begin
        if (in_run == '0) begin
          start_next = MY_IDX;
        end
        run_next   = in_run + 1'b1;
        found_next = (in_run + 1'b1) == need;
      end
    end
  end

  // Entry update: clear on the free wave, set when the run is marked.
  always_comb begin
    entry_next = entry;
    if (clear_here) begin
      entry_next = '0;
    end else if (ctrl.mark && MY_IDX >= mark_start && MY_CNT < mark_end) begin
      entry_next                     = '0;
      entry_next[bth_pkg::ENT_TAKEN] = 1'b1;
      entry_next[bth_pkg::ENT_FIRST] = MY_IDX == mark_start;
      entry_next[bth_pkg::ENT_NEXT]  = MY_NEXT < mark_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry     <= '0;
      out_valid <= 1'b0;
    end else begin
      entry     <= entry_next;
      out_valid <= in_valid;
    end
  end

  // Wave payload holds its last value once the wave has passed.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_run   <= run_next;
      out_start <= start_next;
      out_found <= found_next;
      out_clr   <= clear_here && entry[bth_pkg::ENT_NEXT];
    end
  end

endmodule
